// ===== rtl/core/cat_pkg.sv =====
// cat_pkg: shared types, character codes and helpers for the argument tokenizer
// used by cat_step, cat_fifo and cmdline_argument_tokenizer; no dependencies
`timescale 1ns / 1ps

package cat_pkg;

    // character codes
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_VT        = 8'h0B;
    localparam logic [7:0] CHAR_FF        = 8'h0C;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_DOUBLE = 2'd1,
        QK_SINGLE = 2'd2
    } quote_kind_t;

    typedef struct packed {
        logic        inside_token;
        quote_kind_t quote_kind;
        logic        escape_pending;
        logic [15:0] token_counter;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        line_done;
        logic [15:0] token_total;
        logic        run_last;
    } result_t;

    // whitespace test
    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        case (c) inside
            CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cat_step.sv =====
// cat_step: combinational parse of one character against the tokenizer state
// depends on cat_pkg
`timescale 1ns / 1ps

module cat_step (
    input  logic [7:0]            char_in,
    input  cat_pkg::parse_state_t cur,
    output cat_pkg::parse_state_t nxt,
    output logic [1:0]            res_count,
    output cat_pkg::result_t      res0,
    output cat_pkg::result_t      res1
);
    import cat_pkg::*;

    logic        do_start;
    logic        emit_char;
    logic        quote_open;
    logic [15:0] cnt_started;

    // counter value once a token start is applied
    assign cnt_started = (!cur.inside_token && cur.token_counter != COUNT_MAX) ?
                         cur.token_counter + 16'd1 : cur.token_counter;

    assign quote_open = (cur.quote_kind == QK_DOUBLE) || (cur.quote_kind == QK_SINGLE);

    // character classification and state update
    always_comb
    begin
        nxt       = cur;
        do_start  = 1'b0;
        emit_char = 1'b0;
        res_count = 2'd0;
        res0      = '0;
        res1      = '0;

        if (char_in == CHAR_NUL)
        begin
            // end of line: flush pending backslash, terminate, clear state
            nxt = '0;
            if (cur.escape_pending)
            begin
                res0.byte_out    = CHAR_BACKSLASH;
                res0.byte_valid  = 1'b1;
                res0.token_total = cur.token_counter;
                res1.byte_out    = CHAR_NUL;
                res1.byte_valid  = cur.inside_token;
                res1.line_done   = 1'b1;
                res1.token_total = cur.token_counter;
                res1.run_last    = 1'b1;
                res_count        = 2'd2;
            end
            else
            begin
                res0.byte_out    = CHAR_NUL;
                res0.byte_valid  = cur.inside_token;
                res0.line_done   = 1'b1;
                res0.token_total = cur.token_counter;
                res0.run_last    = 1'b1;
                res_count        = 2'd1;
            end
        end
        else
        begin
            if (cur.escape_pending)
            begin
                nxt.escape_pending = 1'b0;
                emit_char          = 1'b1;
            end
            else if (char_in == CHAR_BACKSLASH)
            begin
                do_start = 1'b1;
                if (cur.quote_kind == QK_SINGLE)
                    emit_char = 1'b1;
                else
                    nxt.escape_pending = 1'b1;
            end
            else if (!quote_open)
            begin
                if (char_in == CHAR_DQUOTE)
                begin
                    do_start       = 1'b1;
                    nxt.quote_kind = QK_DOUBLE;
                end
                else if (char_in == CHAR_SQUOTE)
                begin
                    do_start       = 1'b1;
                    nxt.quote_kind = QK_SINGLE;
                end
                else if (is_blank(char_in))
                begin
                    if (cur.inside_token)
                    begin
                        // token terminator byte
                        res0.byte_out    = CHAR_NUL;
                        res0.byte_valid  = 1'b1;
                        res0.token_total = cur.token_counter;
                        res0.run_last    = 1'b1;
                        res_count        = 2'd1;
                        nxt.inside_token = 1'b0;
                        nxt.quote_kind   = QK_NONE;
                    end
                end
                else
                begin
                    do_start  = 1'b1;
                    emit_char = 1'b1;
                end
            end
            else
            begin
                do_start = 1'b1;
                if ((cur.quote_kind == QK_DOUBLE && char_in == CHAR_DQUOTE) ||
                    (cur.quote_kind == QK_SINGLE && char_in == CHAR_SQUOTE))
                    nxt.quote_kind = QK_NONE;
                else
                    emit_char = 1'b1;
            end

            if (do_start)
            begin
                nxt.inside_token  = 1'b1;
                nxt.token_counter = cnt_started;
            end

            if (emit_char)
            begin
                res0.byte_out    = char_in;
                res0.byte_valid  = 1'b1;
                res0.token_total = do_start ? cnt_started : cur.token_counter;
                res0.run_last    = 1'b1;
                res_count        = 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/cat_fifo.sv =====
// cat_fifo: small result queue, up to two pushes and one pop per cycle
// depends on cat_pkg
`timescale 1ns / 1ps

module cat_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  cat_pkg::result_t push0,
    input  cat_pkg::result_t push1,
    output logic             room_two,
    output logic             head_valid,
    input  logic             pop,
    output cat_pkg::result_t head
);
    import cat_pkg::*;

    result_t            entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign do_pop     = pop && head_valid;
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign room_two   = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    // pointer and fill updates
    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(do_pop);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_inc] <= push1;
    end

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    // pushes only arrive with room for them
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room_two)
        else $error("result queue push without room");

    // fill level tracks pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(push_n))
                 - CNT_W'($past(do_pop)))
        else $error("result queue count mismatch");

endmodule

// ===== rtl/core/cmdline_argument_tokenizer.sv =====
// cmdline_argument_tokenizer: top level, input register, parse step, result queue
// depends on cat_pkg, cat_step, cat_fifo
`timescale 1ns / 1ps

// Takes one command line character per request and returns the packed token
// bytes, each token followed by a zero byte; a zero character ends the line and
// its final result carries line_done with the saturating token count. Quotes
// group text and are dropped, a backslash escapes the next character except
// inside single quotes. One character is accepted per cycle unless the input
// stalls: it lands in an input register, is parsed from there once the queue can
// take two results, and its results enter a four-entry result queue that drains
// one result per cycle while out_ready is high. Most characters give zero or one
// result; an end of line after a pending backslash gives two, and the input
// stalls only while the queue holds more than two results. The first result of a
// character passes the input register and the result queue before it shows.

module cmdline_argument_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  byte_out,
    output logic        byte_valid,
    output logic        line_done,
    output logic [15:0] token_total,
    output logic        run_last,
    output logic        out_valid,
    input  logic        out_ready
);
    import cat_pkg::*;

    logic         hold_valid_reg;
    logic         hold_valid_next;
    logic [7:0]   hold_char_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_nxt;
    logic [1:0]   step_count;
    result_t      step_res0;
    result_t      step_res1;
    logic [1:0]   push_n;
    logic         room_two;
    logic         proceed;
    result_t      head;

    // parse the held character when the queue can take two results
    assign proceed  = hold_valid_reg && room_two;
    assign in_ready = !hold_valid_reg || proceed;
    assign push_n   = proceed ? step_count : 2'd0;

    assign hold_valid_next = (in_valid && in_ready) || (hold_valid_reg && !proceed);
    assign state_next      = proceed ? step_nxt : state_reg;

    cat_step u_step (
        .char_in   (hold_char_reg),
        .cur       (state_reg),
        .nxt       (step_nxt),
        .res_count (step_count),
        .res0      (step_res0),
        .res1      (step_res1)
    );

    cat_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (step_res0),
        .push1      (step_res1),
        .room_two   (room_two),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head       (head)
    );

    // input register and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            state_reg      <= state_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_char_reg <= char_in;
    end

    // output fields from queue head
    assign byte_out    = head.byte_out;
    assign byte_valid  = head.byte_valid;
    assign line_done   = head.line_done;
    assign token_total = head.token_total;
    assign run_last    = head.run_last;

    // end of line is always the last result of its character
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_done) |-> run_last)
        else $error("line_done without run_last");

    // an unwritten byte only appears as an empty end of line
    a_invalid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (line_done && byte_out == CHAR_NUL))
        else $error("invalid byte outside end of line");

    // a held character waiting for queue room keeps its value
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !proceed) |=> (hold_valid_reg && $stable(hold_char_reg)))
        else $error("held character lost while stalled");

    // parser state is cleared after an end of line
    a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && hold_char_reg == CHAR_NUL) |=> (state_reg == '0))
        else $error("state not cleared at end of line");

endmodule

// ===== tb/cat_token_checker.sv =====
// cat_token_checker: watches both request channels of the argument tokenizer,
// predicts the token bytes and compares them in order; depends on cat_pkg
`timescale 1ns / 1ps

module cat_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_out,
    input  logic        byte_valid,
    input  logic        line_done,
    input  logic [15:0] token_total,
    input  logic        run_last,
    input  logic        out_valid,
    input  logic        out_ready,
    output int          fail_count,
    output int          results_owed
);
    import cat_pkg::*;

    // predicted parse state
    logic        in_tok;
    quote_kind_t quote_open;
    logic        esc_wait;
    logic [15:0] tok_count;

    result_t owed_q[$];
    int      mismatches = 0;
    int      owed_n = 0;

    assign fail_count   = mismatches;
    assign results_owed = owed_n;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic blank_char(input logic [7:0] c);
        logic r;
        case (c)
            CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic result_t token_byte(input logic [7:0] b, input logic v,
                                           input logic d);
        result_t r;
        r.byte_out    = b;
        r.byte_valid  = v;
        r.line_done   = d;
        r.token_total = tok_count;
        r.run_last    = 1'b0;
        return r;
    endfunction

    task automatic clear_line();
        in_tok     = 1'b0;
        quote_open = QK_NONE;
        esc_wait   = 1'b0;
        tok_count  = '0;
    endtask

    // first character of a token bumps the saturating count
    task automatic open_token();
        if (!in_tok)
        begin
            in_tok = 1'b1;
            if (tok_count != COUNT_MAX)
                tok_count++;
        end
    endtask

    // work out the bytes one character produces
    task automatic tokenize_char(input logic [7:0] c);
        result_t made [2];
        int      n;
        n = 0;
        if (c == CHAR_NUL)
        begin
            // end of line: a pending backslash is kept as a byte
            if (esc_wait)
            begin
                made[n] = token_byte(CHAR_BACKSLASH, 1'b1, 1'b0);
                n++;
            end
            made[n] = token_byte(8'h00, in_tok, 1'b1);
            n++;
            clear_line();
        end
        else if (esc_wait)
        begin
            esc_wait = 1'b0;
            made[n] = token_byte(c, 1'b1, 1'b0);
            n++;
        end
        else if (c == CHAR_BACKSLASH)
        begin
            open_token();
            if (quote_open == QK_SINGLE)
            begin
                made[n] = token_byte(c, 1'b1, 1'b0);
                n++;
            end
            else
            begin
                esc_wait = 1'b1;
            end
        end
        else if (quote_open == QK_NONE)
        begin
            if (c == CHAR_DQUOTE)
            begin
                open_token();
                quote_open = QK_DOUBLE;
            end
            else if (c == CHAR_SQUOTE)
            begin
                open_token();
                quote_open = QK_SINGLE;
            end
            else if (blank_char(c))
            begin
                if (in_tok)
                begin
                    made[n] = token_byte(8'h00, 1'b1, 1'b0);
                    n++;
                    in_tok = 1'b0;
                end
            end
            else
            begin
                open_token();
                made[n] = token_byte(c, 1'b1, 1'b0);
                n++;
            end
        end
        else
        begin
            // inside quotes only the matching quote is special
            open_token();
            if ((quote_open == QK_DOUBLE && c == CHAR_DQUOTE) ||
                (quote_open == QK_SINGLE && c == CHAR_SQUOTE))
            begin
                quote_open = QK_NONE;
            end
            else
            begin
                made[n] = token_byte(c, 1'b1, 1'b0);
                n++;
            end
        end
        if (n > 0)
            made[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            owed_q.push_back(made[i]);
    endtask

    task automatic check_result();
        result_t want;
        if (owed_q.size() == 0)
        begin
            report_mismatch("unexpected result byte", {8'h00, byte_out}, 16'h0000);
        end
        else
        begin
            want = owed_q.pop_front();
            if (byte_out !== want.byte_out)
                report_mismatch("byte_out", {8'h00, byte_out}, {8'h00, want.byte_out});
            if (byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", {15'h0, byte_valid}, {15'h0, want.byte_valid});
            if (line_done !== want.line_done)
                report_mismatch("line_done", {15'h0, line_done}, {15'h0, want.line_done});
            if (token_total !== want.token_total)
                report_mismatch("token_total", token_total, want.token_total);
            if (run_last !== want.run_last)
                report_mismatch("run_last", {15'h0, run_last}, {15'h0, want.run_last});
        end
    endtask

    // compare outgoing bytes, then predict from the accepted character
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            owed_q.delete();
            owed_n = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                tokenize_char(char_in);
            owed_n = owed_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: drives command lines into cmdline_argument_tokenizer with random stalls
// on both sides; depends on cat_pkg, the tokenizer RTL and cat_token_checker
`timescale 1ns / 1ps

module tb;
    import cat_pkg::*;

    localparam int RANDOM_CHARS   = 1200;
    localparam int CALM_TAIL      = 200;
    localparam int LONG_HOLD      = 60;
    localparam int QUIET_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int N_DIRECTED     = 31;

    localparam logic [7:0] DIRECTED_CHARS [N_DIRECTED] = '{
        // empty line
        CHAR_NUL,
        // plain token between blanks, extreme byte values
        CHAR_SPACE, 8'h61, 8'hFF, CHAR_TAB,
        // double quotes keep a blank and an escaped quote
        CHAR_DQUOTE, 8'h62, CHAR_SPACE, CHAR_BACKSLASH, CHAR_DQUOTE, CHAR_DQUOTE, CHAR_CR,
        // backslash is ordinary inside single quotes
        CHAR_SQUOTE, CHAR_BACKSLASH, CHAR_SQUOTE, CHAR_VT,
        // escaped backslash, escaped blank, then the line ends inside a token
        CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_SPACE, CHAR_FF,
        8'h01, 8'h80, 8'h7E, CHAR_NUL,
        // trailing backslash is kept
        CHAR_BACKSLASH, CHAR_NUL,
        // quote left open runs to end of line
        CHAR_SQUOTE, 8'h71, CHAR_SPACE, CHAR_NUL
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  char_in;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        line_done;
    logic [15:0] token_total;
    logic        run_last;
    logic        out_valid;
    logic        out_ready;

    int fail_count;
    int results_owed;
    int chars_sent = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b0;
    bit long_hold_req = 1'b0;

    cmdline_argument_tokenizer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_out   (byte_out),
        .byte_valid (byte_valid),
        .line_done  (line_done),
        .token_total(token_total),
        .run_last   (run_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    cat_token_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_out    (byte_out),
        .byte_valid  (byte_valid),
        .line_done   (line_done),
        .token_total (token_total),
        .run_last    (run_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fail_count  (fail_count),
        .results_owed(results_owed)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles where neither channel moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [7:0] blank_pick();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = CHAR_TAB;
            1: b = CHAR_LF;
            2: b = CHAR_VT;
            3: b = CHAR_FF;
            4: b = CHAR_CR;
            default: b = CHAR_SPACE;
        endcase
        return b;
    endfunction

    // any byte that is not blank, quote, backslash or zero
    function automatic logic [7:0] plain_pick();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CHAR_DQUOTE || c == CHAR_SQUOTE || c == CHAR_BACKSLASH ||
            c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
            c = 8'h61 + 8'($urandom_range(0, 25));
        return c;
    endfunction

    // closed quoted section with random content
    task automatic add_quoted(ref logic [7:0] q[$], input logic [7:0] mark);
        logic [7:0] c;
        q.push_back(mark);
        repeat ($urandom_range(0, 5))
        begin
            c = 8'($urandom_range(1, 255));
            if (c == mark)
                c = CHAR_SPACE;
            q.push_back(c);
            // in double quotes the backslash takes the next byte along
            if (mark == CHAR_DQUOTE && c == CHAR_BACKSLASH)
                q.push_back(8'($urandom_range(1, 255)));
        end
        q.push_back(mark);
    endtask

    // one character request, called and returning at a falling edge
    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        char_in  <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [7:0] line_q[$];
        int         random_start;
        int         n_tok;
        bit         hold_done;
        bit         drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n    = 1'b0;
        char_in  = 8'h00;
        in_valid = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corner cases, no idling
        foreach (DIRECTED_CHARS[i])
            send_char(DIRECTED_CHARS[i]);

        // random lines, mostly well-formed
        idle_on = 1'b1;
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            line_q.delete();
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                    line_q.push_back(blank_pick());
                n_tok = $urandom_range(1, 5);
                for (int t = 0; t < n_tok; t++)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        case ($urandom_range(0, 3))
                            0: repeat ($urandom_range(1, 4)) line_q.push_back(plain_pick());
                            1: add_quoted(line_q, CHAR_DQUOTE);
                            2: add_quoted(line_q, CHAR_SQUOTE);
                            default:
                            begin
                                line_q.push_back(CHAR_BACKSLASH);
                                line_q.push_back(8'($urandom_range(1, 255)));
                            end
                        endcase
                    end
                    if (t < n_tok - 1 || $urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 3)) line_q.push_back(blank_pick());
                end
            end
            else
            begin
                // noise heavy on special bytes, may end inside quotes or escape
                repeat ($urandom_range(0, 12))
                begin
                    case ($urandom_range(0, 5))
                        0: line_q.push_back(CHAR_BACKSLASH);
                        1: line_q.push_back(CHAR_DQUOTE);
                        2: line_q.push_back(CHAR_SQUOTE);
                        3: line_q.push_back(blank_pick());
                        default: line_q.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end
            line_q.push_back(CHAR_NUL);
            foreach (line_q[i])
                send_char(line_q[i]);

            // receiver holds off while requests keep coming
            if (!hold_done && chars_sent - random_start >= 400)
            begin
                hold_done = 1'b1;
                long_hold_req = 1'b1;
            end
            // sender pauses until every byte is out
            if (!drain_done && chars_sent - random_start >= 800)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (results_owed != 0);
            end
            if (chars_sent - random_start >= RANDOM_CHARS - CALM_TAIL)
                idle_on = 1'b0;
        end

        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cat_pkg.sv
rtl/core/cat_step.sv
rtl/core/cat_fifo.sv
rtl/core/cmdline_argument_tokenizer.sv
tb/cat_token_checker.sv
tb/tb.sv
